// ===== src/grm_pkg.sv =====
// grm_pkg: shared types, widths and constants of the gain ramp mixer
// no dependencies; imported by every module of the block

package grm_pkg;

  // fixed field widths
  localparam int CHAN_W     = 8;
  localparam int GAIN_W     = 17;   // Q1.16 gain at the ports
  localparam int CUR_W      = 31;   // Q1.30 gain inside, never negative, at most 1.0
  localparam int STEP_W     = 32;   // signed Q2.30 ramp increment
  localparam int FACT_W     = 24;   // Q0.24 smoothing factor
  localparam int BLEN_W     = 13;
  localparam int PSUM_W     = 32;
  localparam int Q_GAP      = 14;   // Q1.16 to Q1.30 shift
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  // defaults of the top-level parameters
  localparam int CHANNELS_DEF    = 256;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam logic [GAIN_W-1:0] ONE_Q16 = 17'd65536;

  // configuration reset values
  localparam logic              INTERP_RST = 1'b0;
  localparam logic [FACT_W-1:0] FACTOR_RST = 24'd16609444;
  localparam logic [GAIN_W-1:0] SMALL_RST  = 17'd1;
  localparam logic [BLEN_W-1:0] BLEN_RST   = 13'd512;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERP_MODE = 2'd0,
    CFG_GAIN_FACTOR = 2'd1,
    CFG_SMALL_GAIN  = 2'd2,
    CFG_BLOCK_LEN   = 2'd3
  } grm_cfg_idx_e;

  // per-channel mode
  typedef enum logic [1:0] {
    MODE_SKIP   = 2'd0,
    MODE_HOLD   = 2'd1,
    MODE_LIN    = 2'd2,
    MODE_SMOOTH = 2'd3
  } grm_mode_e;

  // one channel entry of the state memory
  typedef struct packed {
    grm_mode_e                mode;
    logic [CUR_W-1:0]         cur;
    logic [GAIN_W-1:0]        goal;
    logic signed [STEP_W-1:0] step;
  } grm_entry_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BLK_READ,
    ST_BLK_DIV,
    ST_BLK_WRITE,
    ST_SMP_UPD,
    ST_SMP_SMUL,
    ST_SMP_SAPPLY,
    ST_SMP_MMUL,
    ST_SMP_MSUM
  } grm_state_e;

  // source of the applied gain
  typedef enum logic [1:0] {
    GSEL_ZERO,
    GSEL_HOLD,
    GSEL_LIN,
    GSEL_SMOOTH
  } grm_gsel_e;

  // kind of state memory write
  typedef enum logic [2:0] {
    WSEL_NONE,
    WSEL_LIN,
    WSEL_SMOOTH,
    WSEL_SKIP,
    WSEL_JUMP,
    WSEL_RAMP
  } grm_wsel_e;

  // controller to datapath
  typedef struct packed {
    logic      capture;
    logic      load_g;
    grm_gsel_e g_sel;
    grm_wsel_e wr_sel;
    logic      sm_prep;
    logic      sm_mul;
    logic      mx_mul;
    logic      mx_load;
    logic      div_start;
  } grm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic      chan_ok;
    logic      skip;
    grm_mode_e mode;
    logic      fade;
    logic      jump;
    logic      div_done;
    logic      out_busy;
  } grm_status_t;

endpackage

// ===== src/grm_div.sv =====
// grm_div: restoring divider, one quotient bit per cycle
// depends on grm_pkg for the gain and block length widths

module grm_div import grm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CUR_W-1:0]  dividend_i,
  input  logic [BLEN_W-1:0] divisor_i,
  output logic [CUR_W-1:0]  quot_o,
  output logic              done_o
);

  localparam int CNT_W = $clog2(CUR_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(CUR_W - 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [BLEN_W-1:0] rem_q, rem_d, den_q;
  logic [CUR_W-1:0]  quot_q, quot_d;
  logic [BLEN_W:0]   shifted, trial;
  logic              ge;

  // one trial subtraction
  always_comb begin
    shifted = {rem_q, quot_q[CUR_W-1]};
    trial   = shifted - {1'b0, den_q};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = ge ? trial[BLEN_W-1:0] : shifted[BLEN_W-1:0];
    quot_d  = {quot_q[CUR_W-2:0], ge};
  end

  // step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // remainder and quotient shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= dividend_i;
      den_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

// ===== src/grm_ctrl.sv =====
// grm_ctrl: sequencing state machine of the gain ramp mixer
// depends on grm_pkg for states, commands and status

module grm_ctrl import grm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        cmd_i,
  output logic        in_stall_o,
  input  grm_status_t status_i,
  output grm_cmd_t    cmd_o
);

  grm_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = cmd_i ? ST_BLK_READ : ST_SMP_UPD;
        end
      end
      // block start: drop a bad channel, skip, or start the slope division
      ST_BLK_READ: begin
        if (!status_i.chan_ok) begin
          state_d = ST_IDLE;
        end else if (status_i.skip) begin
          cmd_o.wr_sel = WSEL_SKIP;
          state_d = ST_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = ST_BLK_DIV;
        end
      end
      ST_BLK_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_BLK_WRITE;
        end
      end
      ST_BLK_WRITE: begin
        cmd_o.wr_sel = status_i.jump ? WSEL_JUMP : WSEL_RAMP;
        state_d = ST_IDLE;
      end
      // sample: pick the gain by channel mode
      ST_SMP_UPD: begin
        cmd_o.load_g = 1'b1;
        cmd_o.g_sel  = GSEL_ZERO;
        state_d      = ST_SMP_MMUL;
        if (status_i.chan_ok) begin
          case (status_i.mode)
            MODE_HOLD: cmd_o.g_sel = GSEL_HOLD;
            MODE_LIN: begin
              cmd_o.g_sel  = GSEL_LIN;
              cmd_o.wr_sel = WSEL_LIN;
            end
            MODE_SMOOTH: begin
              if (!status_i.fade) begin
                cmd_o.load_g  = 1'b0;
                cmd_o.sm_prep = 1'b1;
                state_d       = ST_SMP_SMUL;
              end
            end
            default: cmd_o.g_sel = GSEL_ZERO;
          endcase
        end
      end
      ST_SMP_SMUL: begin
        cmd_o.sm_mul = 1'b1;
        state_d = ST_SMP_SAPPLY;
      end
      ST_SMP_SAPPLY: begin
        cmd_o.load_g = 1'b1;
        cmd_o.g_sel  = GSEL_SMOOTH;
        cmd_o.wr_sel = WSEL_SMOOTH;
        state_d = ST_SMP_MMUL;
      end
      ST_SMP_MMUL: begin
        cmd_o.mx_mul = 1'b1;
        state_d = ST_SMP_MSUM;
      end
      // wait for a free output register
      ST_SMP_MSUM: begin
        if (!status_i.out_busy) begin
          cmd_o.mx_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== src/grm_datapath.sv =====
// grm_datapath: config registers, channel state memory, gain update and mixing
// depends on grm_pkg and grm_div

module grm_datapath import grm_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  // input fields
  input  logic [CHAN_W-1:0]             channel_i,
  input  logic [GAIN_W-1:0]             target_gain_i,
  input  logic                          skip_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [PSUM_W-1:0]      partial_sum_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [PSUM_W-1:0]      mix_out_o,
  output logic [GAIN_W-1:0]             gain_used_o,
  // controller link
  input  grm_cmd_t                      cmd_in_i,
  output grm_status_t                   status_o
);

  localparam int DEPTH  = (CHANNELS < (1 << CHAN_W)) ? CHANNELS : (1 << CHAN_W);
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MP_W   = SAMPLE_BITS + GAIN_W;
  localparam int P_W    = SAMPLE_BITS + 2;
  localparam int SUM_W  = (SAMPLE_BITS + 3 > 34) ? SAMPLE_BITS + 3 : 34;
  localparam int SP_W   = CUR_W + FACT_W;

  // configuration registers
  logic              interp_q;
  logic [FACT_W-1:0] factor_q;
  logic [GAIN_W-1:0] small_q;
  logic [BLEN_W-1:0] blen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_q <= INTERP_RST;
      factor_q <= FACTOR_RST;
      small_q  <= SMALL_RST;
      blen_q   <= BLEN_RST;
    end else if (cfg_we_i) begin
      case (grm_cfg_idx_e'(cfg_index_i))
        CFG_INTERP_MODE: interp_q <= cfg_data_i[0];
        CFG_GAIN_FACTOR: factor_q <= cfg_data_i[FACT_W-1:0];
        CFG_SMALL_GAIN:  small_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_BLOCK_LEN:   blen_q   <= cfg_data_i[BLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // captured transaction fields
  logic                   skip_q, samp_neg_q;
  logic [CHAN_W-1:0]      chan_q;
  logic [GAIN_W-1:0]      tgt_q, tgt_sat;
  logic [SAMPLE_BITS-1:0] samp_mag_q;
  logic signed [PSUM_W-1:0] psum_q;

  assign tgt_sat = (target_gain_i > ONE_Q16) ? ONE_Q16 : target_gain_i;

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.capture) begin
      chan_q     <= channel_i;
      tgt_q      <= tgt_sat;
      skip_q     <= skip_i;
      samp_neg_q <= sample_i[SAMPLE_BITS-1];
      samp_mag_q <= sample_i[SAMPLE_BITS-1] ? (~sample_i + 1'b1) : sample_i;
      psum_q     <= partial_sum_i;
    end
  end

  // channel state memory, entries valid once written
  grm_entry_t       mem_q [DEPTH];
  grm_entry_t       rd_q, ent, wr_ent;
  logic [DEPTH-1:0] vld_q;
  logic             rd_vld_q, wr_en, chan_ok;
  logic [IDX_W-1:0] ridx, widx;

  assign ridx    = channel_i[IDX_W-1:0];
  assign widx    = chan_q[IDX_W-1:0];
  assign chan_ok = ({{(32-CHAN_W){1'b0}}, chan_q} < 32'(CHANNELS));
  assign wr_en   = (cmd_in_i.wr_sel != WSEL_NONE) && chan_ok;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[widx] <= wr_ent;
    end
    if (cmd_in_i.capture) begin
      rd_q <= mem_q[ridx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[widx] <= 1'b1;
      end
      if (cmd_in_i.capture) begin
        rd_vld_q <= vld_q[ridx];
      end
    end
  end

  // never-written entry reads as skipped with zero gain
  assign ent = rd_vld_q ? rd_q : '0;

  // thresholds and goals in Q1.30
  logic [CUR_W-1:0] thr, g30_goal, g30_tgt;
  assign thr      = {small_q, {Q_GAP{1'b0}}};
  assign g30_goal = {ent.goal, {Q_GAP{1'b0}}};
  assign g30_tgt  = {tgt_q, {Q_GAP{1'b0}}};

  // linear ramp step, clamped at the goal
  logic signed [CUR_W+1:0] lin_sum, g30_ext;
  logic                    lin_clamp;
  logic [CUR_W-1:0]        lin_cur;
  always_comb begin
    lin_sum   = $signed({2'b00, ent.cur}) + $signed({ent.step[STEP_W-1], ent.step});
    g30_ext   = $signed({2'b00, g30_goal});
    lin_clamp = ((!ent.step[STEP_W-1] && (ent.step != '0)) && (lin_sum > g30_ext)) ||
                (ent.step[STEP_W-1] && (lin_sum < g30_ext));
    lin_cur   = lin_clamp ? g30_goal : lin_sum[CUR_W-1:0];
  end

  // smoothing: distance to goal times factor
  logic              sm_neg_q, sm_neg;
  logic [CUR_W-1:0]  sm_mag_q, sm_mag, sm_r, sm_cur;
  logic [SP_W-1:0]   sm_prod_q;
  assign sm_neg = ent.cur < g30_goal;
  assign sm_mag = sm_neg ? (g30_goal - ent.cur) : (ent.cur - g30_goal);
  assign sm_r   = sm_prod_q[SP_W-1:FACT_W];
  assign sm_cur = sm_neg_q ? (g30_goal - sm_r) : (g30_goal + sm_r);

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.sm_prep) begin
      sm_neg_q <= sm_neg;
      sm_mag_q <= sm_mag;
    end
    if (cmd_in_i.sm_mul) begin
      sm_prod_q <= SP_W'(sm_mag_q) * SP_W'(factor_q);
    end
  end

  // block start: slope division and jump decision
  logic              bs_neg, div_done;
  logic [CUR_W-1:0]  bs_mag, div_mag_q, quot;
  logic              div_neg_q;
  logic [BLEN_W-1:0] blen_eff;
  logic [STEP_W-1:0] ramp_step;
  logic              jump;

  assign bs_neg   = g30_tgt < ent.cur;
  assign bs_mag   = bs_neg ? (ent.cur - g30_tgt) : (g30_tgt - ent.cur);
  assign blen_eff = (blen_q == '0) ? BLEN_W'(1) : blen_q;

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.div_start) begin
      div_neg_q <= bs_neg;
      div_mag_q <= bs_mag;
    end
  end

  grm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_in_i.div_start),
    .dividend_i (bs_mag),
    .divisor_i  (blen_eff),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  assign jump      = (quot == '0) || (div_mag_q < thr);
  assign ramp_step = div_neg_q ? (~{1'b0, quot} + 1'b1) : {1'b0, quot};

  // entry to write back
  always_comb begin
    wr_ent = ent;
    case (cmd_in_i.wr_sel)
      WSEL_LIN:    wr_ent.cur = lin_cur;
      WSEL_SMOOTH: wr_ent.cur = sm_cur;
      WSEL_SKIP:   wr_ent.mode = MODE_SKIP;
      WSEL_JUMP: begin
        wr_ent.cur  = g30_tgt;
        wr_ent.goal = tgt_q;
        wr_ent.mode = MODE_HOLD;
      end
      WSEL_RAMP: begin
        wr_ent.step = ramp_step;
        wr_ent.goal = tgt_q;
        wr_ent.mode = interp_q ? MODE_SMOOTH : MODE_LIN;
      end
      default: wr_ent = ent;
    endcase
  end

  // applied gain in Q1.16
  logic [GAIN_W-1:0] g_q, g_d;
  always_comb begin
    case (cmd_in_i.g_sel)
      GSEL_HOLD:   g_d = (ent.cur >= thr) ? ent.cur[CUR_W-1:Q_GAP] : '0;
      GSEL_LIN:    g_d = lin_cur[CUR_W-1:Q_GAP];
      GSEL_SMOOTH: g_d = sm_cur[CUR_W-1:Q_GAP];
      default:     g_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.load_g) begin
      g_q <= g_d;
    end
  end

  // sample times gain
  logic [MP_W-1:0] mx_prod_q;
  always_ff @(posedge clk_i) begin
    if (cmd_in_i.mx_mul) begin
      mx_prod_q <= MP_W'(samp_mag_q) * MP_W'(g_q);
    end
  end

  // round to nearest, add partial sum, saturate
  logic [MP_W:0]           rnd;
  logic [P_W-1:0]          p;
  logic signed [SUM_W-1:0] ps_ext, p_ext, sum;
  logic                    ovf;
  logic signed [PSUM_W-1:0] mix_d;
  always_comb begin
    rnd    = {1'b0, mx_prod_q} + (MP_W+1)'(32768);
    p      = rnd[MP_W:16];
    ps_ext = {{(SUM_W-PSUM_W){psum_q[PSUM_W-1]}}, psum_q};
    p_ext  = {{(SUM_W-P_W){1'b0}}, p};
    sum    = samp_neg_q ? (ps_ext - p_ext) : (ps_ext + p_ext);
    ovf    = !((&sum[SUM_W-1:PSUM_W-1]) || !(|sum[SUM_W-1:PSUM_W-1]));
    if (ovf) begin
      mix_d = sum[SUM_W-1] ? {1'b1, {(PSUM_W-1){1'b0}}} : {1'b0, {(PSUM_W-1){1'b1}}};
    end else begin
      mix_d = sum[PSUM_W-1:0];
    end
  end

  // output register
  logic                     out_valid_q;
  logic signed [PSUM_W-1:0] out_mix_q;
  logic [GAIN_W-1:0]        out_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_in_i.mx_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.mx_load) begin
      out_mix_q  <= mix_d;
      out_gain_q <= g_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mix_out_o   = out_mix_q;
  assign gain_used_o = out_gain_q;

  // status to the controller
  always_comb begin
    status_o          = '0;
    status_o.chan_ok  = chan_ok;
    status_o.skip     = skip_q;
    status_o.mode     = ent.mode;
    status_o.fade     = (ent.goal < small_q) && (ent.cur < thr);
    status_o.jump     = jump;
    status_o.div_done = div_done;
    status_o.out_busy = out_valid_q && out_stall_i;
  end

endmodule

// ===== src/gain_ramp_mixer_core.sv =====
// gain_ramp_mixer_core: top level of the per-channel gain smoother and mixer
// depends on grm_pkg, grm_ctrl, grm_datapath (and grm_div below it)
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------------
//   input    | in_valid_i/in_stall_o | cmd, channel, target_gain, skip, sample, partial_sum
//   output   | out_valid_o/out_stall_i | mix_out, gain_used
//   config   | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one transaction at a time: a sample runs update, multiply and output load, with factor
// multiply and apply between if its channel is smoothing, not fading; a sample yields one
// result, a block start none; a block start reads, divides on the 31-step slope divider,
// writes back; skip ends after the read; a full, stalled output register holds the block
// in its last sample state; reset clears per-channel valid bits at once, no clearing pass

module gain_ramp_mixer_core import grm_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [CHAN_W-1:0]             channel_i,
  input  logic [GAIN_W-1:0]             target_gain_i,
  input  logic                          skip_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [PSUM_W-1:0]      partial_sum_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [PSUM_W-1:0]      mix_out_o,
  output logic [GAIN_W-1:0]             gain_used_o
);

  grm_cmd_t    cmd;
  grm_status_t status;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  grm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  grm_datapath #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .channel_i     (channel_i),
    .target_gain_i (target_gain_i),
    .skip_i        (skip_i),
    .sample_i      (sample_i),
    .partial_sum_i (partial_sum_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .mix_out_o     (mix_out_o),
    .gain_used_o   (gain_used_o),
    .cmd_in_i      (cmd),
    .status_o      (status)
  );

endmodule

// ===== src/grm_checker.sv =====
// grm_checker: port-level checks of the gain ramp mixer, bound to the top level
// depends on grm_pkg and gain_ramp_mixer_core

module grm_checker import grm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [GAIN_W-1:0] gain_used_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one transaction in flight: stall right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a transaction is in flight");

  // a new result only appears at the end of a transaction's work
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a transaction in flight");

  // applied gain never above unity
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> gain_used_o <= ONE_Q16)
    else $error("gain_used above unity");

endmodule

bind gain_ramp_mixer_core grm_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .gain_used_o (gain_used_o)
);
